// ===== hw/rtl/irpwd_pkg.sv =====
`timescale 1ns / 1ps

package irpwd_pkg;

  // default packet length in bits
  localparam int unsigned PacketBitsDefault = 12;

  // payload widths
  localparam int unsigned WidthW    = 8;
  localparam int unsigned CodeW     = 12;
  localparam int unsigned LedW      = 8;
  localparam int unsigned HeaderW   = 3;
  localparam int unsigned KeyW      = 6;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 8;

  // configuration register indexes
  localparam logic [CfgIndexW-1:0] CfgBitThreshold = 2'd0;
  localparam logic [CfgIndexW-1:0] CfgHeaderCode   = 2'd1;

  // register reset values
  localparam logic [WidthW-1:0]  ThresholdReset = 8'd71;
  localparam logic [HeaderW-1:0] HeaderReset    = 3'b101;

  // packet field positions
  localparam int unsigned HeaderLsb = 9;
  localparam int unsigned FlagHBit  = 8;
  localparam int unsigned FlagS1Bit = 7;

  // key codes
  localparam logic [KeyW-1:0] KeyLedA = 6'b001000;
  localparam logic [KeyW-1:0] KeyLedB = 6'b010000;
  localparam logic [KeyW-1:0] KeyLedC = 6'b100000;

  // active-low led port values
  localparam logic [LedW-1:0] LedOff    = 8'hFF;
  localparam logic [LedW-1:0] LedA      = ~8'h08;
  localparam logic [LedW-1:0] LedB      = ~8'h04;
  localparam logic [LedW-1:0] LedC      = ~8'h01;
  localparam logic [LedW-1:0] LedOtherS = ~8'h09;
  localparam logic [LedW-1:0] LedOtherH = ~8'h06;

endpackage

// ===== hw/rtl/irpwd_if.sv =====
`timescale 1ns / 1ps

// pulse width input channel
interface irpwd_in_if
  import irpwd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [WidthW-1:0] pulse_width;

  modport source (output valid, output pulse_width, input ready);
  modport sink   (input valid, input pulse_width, output ready);
endinterface

// decoded result channel
interface irpwd_out_if
  import irpwd_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CodeW-1:0] packet_code;
  logic             packets_match;
  logic             header_ok;
  logic             led_update;
  logic [LedW-1:0]  led_value;

  modport source (output valid, output packet_code, output packets_match,
                  output header_ok, output led_update, output led_value,
                  input ready);
  modport sink   (input valid, input packet_code, input packets_match,
                  input header_ok, input led_update, input led_value,
                  output ready);
endinterface

// configuration write channel
interface irpwd_cfg_if
  import irpwd_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CfgIndexW-1:0] index;
  logic [CfgDataW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/ir_pulse_width_command_decoder_unit.sv =====
`timescale 1ns / 1ps

// infrared pulse width command decoder
//
// in_i carries one measured pulse width per transaction. a width above the
// bit threshold is a one bit; bits fill a packet msb first, and two packets
// make a pair. on the transaction that completes the second packet, one
// result is placed on out_o: the first packet, whether both packets match,
// whether the header equals the configured code, and the active-low led port
// value with a flag telling whether it was written.
// throughput is one pulse per cycle while in_i.ready is high, set by the
// single insert and decode stage. a result is valid in the cycle after its
// completing transaction. the result register frees the input side: while a
// result waits on a stalled receiver, pulses are still taken, and in_i.ready
// drops only for a pulse that would complete the next pair.
// cfg_i is always ready; index 0 is the bit threshold, index 1 the header
// code, other indexes are ignored.
// reset restores threshold 71, header code 5, empty packets, led port all off
// and an empty result register.
module ir_pulse_width_command_decoder_unit
  import irpwd_pkg::*;
#(
  parameter int unsigned PacketBits = PacketBitsDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  irpwd_cfg_if.sink      cfg_i,
  irpwd_in_if.sink       in_i,
  irpwd_out_if.source    out_o
);

  localparam int unsigned PosW = (PacketBits > 1) ? $clog2(PacketBits) : 1;
  localparam int unsigned ExtW = (PacketBits > CodeW) ? PacketBits : CodeW;
  localparam logic [PosW-1:0] PosTop = PosW'(PacketBits - 1);

  logic [WidthW-1:0]     threshold_q;
  logic [HeaderW-1:0]    header_q;
  logic [PosW-1:0]       pos_q, pos_d;
  logic                  pair_q, pair_d;
  logic [PacketBits-1:0] first_q, first_d, second_q, second_d;
  logic [PacketBits-1:0] first_ins, second_ins;
  logic [LedW-1:0]       led_q, led_d;

  logic                  out_valid_q;
  logic [CodeW-1:0]      code_q;
  logic                  match_q, hok_q, upd_q;

  logic                  accept, completes, load, one_bit;
  logic [ExtW-1:0]       first_ext;
  logic [CodeW-1:0]      pkt;
  logic                  match, hok, upd, flag_s, flag_h;
  logic [KeyW-1:0]       key;

  // key to led lookup with fallback value
  function automatic logic [LedW-1:0] key_led(logic [KeyW-1:0] k,
                                               logic [LedW-1:0] other);
    logic [LedW-1:0] r;
    case (k)
      KeyLedA: r = LedA;
      KeyLedB: r = LedB;
      KeyLedC: r = LedC;
      default: r = other;
    endcase
    return r;
  endfunction

  // configuration writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= ThresholdReset;
      header_q    <= HeaderReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgBitThreshold: threshold_q <= cfg_i.data[WidthW-1:0];
        CfgHeaderCode:   header_q    <= cfg_i.data[HeaderW-1:0];
        default: ;
      endcase
    end
  end

  // input handshake: stall only a pair-completing pulse behind a full, stalled output
  assign completes = (pos_q == '0) && pair_q;
  assign in_i.ready = !(completes && out_valid_q && !out_o.ready);
  assign accept = in_i.valid && in_i.ready;
  assign load = accept && completes;

  // bit insert
  assign one_bit = in_i.pulse_width > threshold_q;

  always_comb begin
    first_ins  = first_q;
    second_ins = second_q;
    if (one_bit) begin
      if (!pair_q) first_ins[pos_q]  = 1'b1;
      else         second_ins[pos_q] = 1'b1;
    end
  end

  // pair check and led decode on the completed packets
  assign first_ext = ExtW'(first_ins);
  assign pkt       = first_ext[CodeW-1:0];
  assign match     = first_ins == second_ins;
  assign hok       = pkt[HeaderLsb +: HeaderW] == header_q;
  assign key       = pkt[KeyW-1:0];
  assign flag_s    = pkt[FlagS1Bit];
  assign flag_h    = pkt[FlagHBit];
  assign upd       = match && hok && (flag_s || flag_h);

  always_comb begin
    led_d = led_q;
    if (match && hok) begin
      if (flag_h)      led_d = key_led(key, LedOtherH);
      else if (flag_s) led_d = key_led(key, LedOtherS);
    end
  end

  // packet assembly state
  always_comb begin
    pos_d    = pos_q;
    pair_d   = pair_q;
    first_d  = first_q;
    second_d = second_q;
    if (accept) begin
      first_d  = first_ins;
      second_d = second_ins;
      if (pos_q != '0) begin
        pos_d = pos_q - 1'b1;
      end else begin
        pos_d  = PosTop;
        pair_d = !pair_q;
        if (pair_q) begin
          first_d  = '0;
          second_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= PosTop;
      pair_q   <= 1'b0;
      first_q  <= '0;
      second_q <= '0;
      led_q    <= LedOff;
    end else begin
      pos_q    <= pos_d;
      pair_q   <= pair_d;
      first_q  <= first_d;
      second_q <= second_d;
      if (load) led_q <= led_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      code_q  <= pkt;
      match_q <= match;
      hok_q   <= hok;
      upd_q   <= upd;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.packet_code   = code_q;
  assign out_o.packets_match = match_q;
  assign out_o.header_ok     = hok_q;
  assign out_o.led_update    = upd_q;
  assign out_o.led_value     = led_q;

endmodule

// ===== hw/rtl/irpwd_checker.sv =====
`timescale 1ns / 1ps

module irpwd_checker
  import irpwd_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [CodeW-1:0] out_code_i,
  input logic             out_match_i,
  input logic             out_hok_i,
  input logic             out_upd_i,
  input logic [LedW-1:0]  out_led_i
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_code_i) && $stable(out_led_i)
      && $stable(out_match_i) && $stable(out_hok_i) && $stable(out_upd_i))
    else $error("stalled result payload changed");

  // input backpressure only comes from a full, stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without output backpressure");

  // an led write needs a matching pair with a valid header
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_upd_i |-> out_match_i && out_hok_i)
    else $error("led written for an invalid pair");

  // a new result needs an accepted pulse in the cycle before
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !$past(out_valid_i && !out_ready_i) |->
      $past(in_valid_i && in_ready_i))
    else $error("result without an input transaction");

endmodule

bind ir_pulse_width_command_decoder_unit irpwd_checker u_irpwd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_code_i  (out_o.packet_code),
  .out_match_i (out_o.packets_match),
  .out_hok_i   (out_o.header_ok),
  .out_upd_i   (out_o.led_update),
  .out_led_i   (out_o.led_value)
);
